// ===== design/mcml_pkg.sv =====
// Shared types and constants for the MIDI CC mixer level map.
package mcml_pkg;

  typedef enum logic [1:0] {
    A_MIDI  = 2'd0,
    A_LOCAL = 2'd1,
    A_SCAN  = 2'd2,
    A_NOP   = 2'd3
  } mcml_action_e;

  typedef enum logic [1:0] {
    K_APPLY = 2'd0,
    K_SENT  = 2'd1,
    K_FWD   = 2'd2,
    K_DONE  = 2'd3
  } mcml_kind_e;

  typedef enum logic [1:0] {
    T_INPUT  = 2'd0,
    T_COMP   = 2'd1,
    T_MASTER = 2'd2
  } mcml_target_e;

  localparam logic [7:0] CcStatus      = 8'hB0;
  localparam logic [7:0] StatusHiMask  = 8'hF0;
  localparam logic [6:0] CcNumMaster   = 7'd7;
  localparam int         CcNumInBase   = 16;
  localparam logic [6:0] CcNumComp     = 7'd23;

  // Decoded control change.
  typedef struct packed {
    logic         mapped;
    logic [3:0]   chan;
    mcml_target_e target;
    logic [3:0]   in_idx;
  } mcml_dec_t;

  // One result word as driven on the output ports.
  typedef struct packed {
    mcml_kind_e   kind;
    logic [1:0]   bus;
    mcml_target_e target;
    logic [2:0]   in_num;
    logic [4:0]   level;
    logic [7:0]   status;
    logic [6:0]   number;
    logic [6:0]   value;
    logic         last;
  } mcml_res_t;

endpackage

// ===== design/mcml_ram.sv =====
// Generic one-write one-read RAM with registered read data.
module mcml_ram #(
  parameter int Width = 8,
  parameter int Depth = 36
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                          wdata_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                          rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/mcml_cc_decode.sv =====
// Maps a MIDI control change to a mixer slot and apply target.
module mcml_cc_decode #(
  parameter int BUS_COUNT      = 4,
  parameter int INPUTS_PER_BUS = 7,
  parameter int SlotW          = 6
) (
  input  logic [7:0]           status_i,
  input  logic [6:0]           number_i,
  output mcml_pkg::mcml_dec_t  dec_o,
  output logic [SlotW-1:0]     slot_o
);
  import mcml_pkg::*;

  localparam int CompBase   = BUS_COUNT * INPUTS_PER_BUS;
  localparam int MasterBase = CompBase + BUS_COUNT;

  logic       is_cc;
  logic [3:0] chan;

  assign chan  = status_i[3:0];
  assign is_cc = ((status_i & StatusHiMask) == CcStatus) && (int'(chan) < BUS_COUNT);

  always_comb begin
    dec_o        = '0;
    dec_o.chan   = chan;
    dec_o.target = T_INPUT;
    slot_o       = '0;
    if (is_cc) begin
      // The master number is tested first, then the input range, then the compressor.
      if (number_i == CcNumMaster) begin
        dec_o.mapped = 1'b1;
        dec_o.target = T_MASTER;
        slot_o       = SlotW'(MasterBase + int'(chan));
      end else if (int'(number_i) >= CcNumInBase &&
                   int'(number_i) < CcNumInBase + INPUTS_PER_BUS) begin
        dec_o.mapped = 1'b1;
        dec_o.target = T_INPUT;
        dec_o.in_idx = 4'(int'(number_i) - CcNumInBase);
        slot_o       = SlotW'(int'(chan) * INPUTS_PER_BUS + int'(number_i) - CcNumInBase);
      end else if (number_i == CcNumComp) begin
        dec_o.mapped = 1'b1;
        dec_o.target = T_COMP;
        slot_o       = SlotW'(CompBase + int'(chan));
      end
    end
  end

endmodule

// ===== design/mcml_scan_walk.sv =====
// Slot walker for a scan: bus by bus, inputs then compressor then master.
module mcml_scan_walk #(
  parameter int BUS_COUNT      = 4,
  parameter int INPUTS_PER_BUS = 7,
  parameter int SlotW          = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             init_i,
  input  logic             step_i,
  output logic [SlotW-1:0] slot_o,
  output logic [3:0]       bus_o,
  output logic [6:0]       number_o,
  output logic             last_o
);
  import mcml_pkg::*;

  localparam int CompBase   = BUS_COUNT * INPUTS_PER_BUS;
  localparam int MasterBase = CompBase + BUS_COUNT;
  localparam int BusW       = BUS_COUNT > 1 ? $clog2(BUS_COUNT) : 1;
  localparam int SubW       = $clog2(INPUTS_PER_BUS + 2);

  logic [BusW-1:0]  bus_q, bus_d;
  logic [SubW-1:0]  sub_q, sub_d;
  logic [SlotW-1:0] in_slot_q, in_slot_d;
  logic             is_in, is_comp, sub_end;

  assign is_in   = int'(sub_q) < INPUTS_PER_BUS;
  assign is_comp = int'(sub_q) == INPUTS_PER_BUS;
  assign sub_end = int'(sub_q) == INPUTS_PER_BUS + 1;

  always_comb begin
    if (is_in) begin
      slot_o   = in_slot_q;
      number_o = 7'(int'(sub_q) + CcNumInBase);
    end else if (is_comp) begin
      slot_o   = SlotW'(CompBase + int'(bus_q));
      number_o = CcNumComp;
    end else begin
      slot_o   = SlotW'(MasterBase + int'(bus_q));
      number_o = CcNumMaster;
    end
  end

  assign bus_o  = 4'(bus_q);
  assign last_o = sub_end && (int'(bus_q) == BUS_COUNT - 1);

  always_comb begin
    bus_d     = bus_q;
    sub_d     = sub_q;
    in_slot_d = in_slot_q;
    if (init_i) begin
      bus_d     = '0;
      sub_d     = '0;
      in_slot_d = '0;
    end else if (step_i) begin
      if (sub_end) begin
        sub_d = '0;
        bus_d = bus_q + BusW'(1);
      end else begin
        sub_d = sub_q + SubW'(1);
      end
      if (is_in) begin
        in_slot_d = in_slot_q + SlotW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bus_q     <= '0;
      sub_q     <= '0;
      in_slot_q <= '0;
    end else begin
      bus_q     <= bus_d;
      sub_q     <= sub_d;
      in_slot_q <= in_slot_d;
    end
  end

endmodule

// ===== design/midi_cc_mixer_level_map_core.sv =====
// Top level of the MIDI CC mixer level map: sequencer, level stores and result register.
// After reset a clearing pass writes zero to every slot, all BUS_COUNT*(INPUTS_PER_BUS+2)
// of them (36 at the defaults), with busy_o high; a reset value lands the block in the pass.
// A MIDI word yields one forward result (unmapped) or an apply, a sent and a forward result
// (mapped), one result per cycle. A local write leaves busy_o low. A scan walks the level
// stores one slot a cycle through the single read port of each.
// Results are registered and appear in the cycle after they are formed; the receiver cannot stall.
module midi_cc_mixer_level_map_core #(
  parameter int BUS_COUNT      = 4,
  parameter int INPUTS_PER_BUS = 7
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic [1:0] action_i,
  input  logic [7:0] status_byte_i,
  input  logic [6:0] controller_number_i,
  input  logic [6:0] controller_value_i,
  input  logic [5:0] slot_index_i,
  input  logic [7:0] slot_level_i,
  output logic       result_valid_o,
  output logic [1:0] kind_o,
  output logic [1:0] bus_number_o,
  output logic [1:0] target_kind_o,
  output logic [2:0] input_number_o,
  output logic [4:0] apply_level_o,
  output logic [7:0] out_status_o,
  output logic [6:0] out_number_o,
  output logic [6:0] out_value_o,
  output logic       last_o
);
  import mcml_pkg::*;

  localparam int Slots = BUS_COUNT * (INPUTS_PER_BUS + 2);
  localparam int SlotW = $clog2(Slots);

  // One-hot sequencer states.
  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_CLEAR = 7'b0000010,
    ST_APPLY = 7'b0000100,
    ST_SENT  = 7'b0001000,
    ST_FWD   = 7'b0010000,
    ST_SCAN  = 7'b0100000,
    ST_DONE  = 7'b1000000
  } mcml_state_e;

  mcml_state_e state_q, state_d;

  logic accept;
  assign busy_o = (state_q != ST_IDLE);
  assign accept = start_i && !busy_o;

  // The MIDI word is held for the cycles that emit its results.
  logic [7:0] status_q;
  logic [6:0] number_q, value_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_byte_i;
      number_q <= controller_number_i;
      value_q  <= controller_value_i;
    end
  end

  mcml_dec_t        dec;
  logic [SlotW-1:0] dec_slot;

  mcml_cc_decode #(
    .BUS_COUNT     (BUS_COUNT),
    .INPUTS_PER_BUS(INPUTS_PER_BUS),
    .SlotW         (SlotW)
  ) u_decode (
    .status_i(status_q),
    .number_i(number_q),
    .dec_o   (dec),
    .slot_o  (dec_slot)
  );

  // Scan walker. It issues one slot read a cycle; the compare stage sees the data in the following cycle.
  logic             walk_init, walk_step, walk_last;
  logic [SlotW-1:0] walk_slot;
  logic [3:0]       walk_bus;
  logic [6:0]       walk_number;

  mcml_scan_walk #(
    .BUS_COUNT     (BUS_COUNT),
    .INPUTS_PER_BUS(INPUTS_PER_BUS),
    .SlotW         (SlotW)
  ) u_walk (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .init_i  (walk_init),
    .step_i  (walk_step),
    .slot_o  (walk_slot),
    .bus_o   (walk_bus),
    .number_o(walk_number),
    .last_o  (walk_last)
  );

  logic             issue_done_q, issue_done_d;
  logic             cmp_vld_q, cmp_vld_d;
  logic             cmp_last_q;
  logic [SlotW-1:0] cmp_slot_q;
  logic [3:0]       cmp_bus_q;
  logic [6:0]       cmp_number_q;

  // Level stores: the live copy and the copy last reported to the host.
  logic             live_we, rep_we;
  logic [SlotW-1:0] live_waddr, rep_waddr;
  logic [7:0]       live_wdata, rep_wdata, live_rdata, rep_rdata;
  logic [SlotW-1:0] clr_q, clr_d;

  mcml_ram #(.Width(8), .Depth(Slots)) u_live (
    .clk_i  (clk_i),
    .we_i   (live_we),
    .waddr_i(live_waddr),
    .wdata_i(live_wdata),
    .raddr_i(walk_slot),
    .rdata_o(live_rdata)
  );

  mcml_ram #(.Width(8), .Depth(Slots)) u_reported (
    .clk_i  (clk_i),
    .we_i   (rep_we),
    .waddr_i(rep_waddr),
    .wdata_i(rep_wdata),
    .raddr_i(walk_slot),
    .rdata_o(rep_rdata)
  );

  mcml_res_t  res_q, res_d;
  logic       res_valid_q, res_valid_d;
  logic [7:0] midi_level;

  // A mapped control change stores the controller value divided by four.
  assign midi_level = {3'b000, value_q[6:2]};

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    issue_done_d = issue_done_q;
    cmp_vld_d    = 1'b0;
    walk_init    = 1'b0;
    walk_step    = 1'b0;
    live_we      = 1'b0;
    live_waddr   = dec_slot;
    live_wdata   = midi_level;
    rep_we       = 1'b0;
    rep_waddr    = dec_slot;
    rep_wdata    = midi_level;
    res_valid_d  = 1'b0;
    res_d        = '0;
    res_d.kind   = K_APPLY;
    res_d.target = T_INPUT;

    unique case (state_q)
      ST_CLEAR: begin
        live_we    = 1'b1;
        live_waddr = clr_q;
        live_wdata = '0;
        rep_we     = 1'b1;
        rep_waddr  = clr_q;
        rep_wdata  = '0;
        clr_d      = clr_q + SlotW'(1);
        if (int'(clr_q) == Slots - 1) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          unique case (mcml_action_e'(action_i))
            A_MIDI: begin
              state_d = ST_APPLY;
            end
            A_LOCAL: begin
              // Only the live copy changes; the next scan reports the difference.
              live_we    = int'(slot_index_i) < Slots;
              live_waddr = SlotW'(slot_index_i);
              live_wdata = slot_level_i;
            end
            A_SCAN: begin
              walk_init    = 1'b1;
              issue_done_d = 1'b0;
              state_d      = ST_SCAN;
            end
            A_NOP: begin
            end
            default: begin
            end
          endcase
        end
      end

      ST_APPLY: begin
        res_valid_d = 1'b1;
        if (dec.mapped) begin
          live_we      = 1'b1;
          rep_we       = 1'b1;
          res_d.kind   = K_APPLY;
          res_d.bus    = dec.chan[1:0];
          res_d.target = dec.target;
          res_d.in_num = dec.in_idx[2:0];
          res_d.level  = value_q[6:2];
          state_d      = ST_SENT;
        end else begin
          // Anything that is not a mapped control change is only forwarded.
          res_d.kind   = K_FWD;
          res_d.status = status_q;
          res_d.number = number_q;
          res_d.value  = value_q;
          res_d.last   = 1'b1;
          state_d      = ST_IDLE;
        end
      end

      ST_SENT: begin
        res_valid_d  = 1'b1;
        res_d.kind   = K_SENT;
        res_d.status = CcStatus | {4'h0, dec.chan};
        res_d.number = number_q;
        res_d.value  = value_q;
        state_d      = ST_FWD;
      end

      ST_FWD: begin
        res_valid_d  = 1'b1;
        res_d.kind   = K_FWD;
        res_d.status = status_q;
        res_d.number = number_q;
        res_d.value  = value_q;
        res_d.last   = 1'b1;
        state_d      = ST_IDLE;
      end

      ST_SCAN: begin
        // Issue side: one slot read per cycle until the master of the last bus.
        if (!issue_done_q) begin
          walk_step = 1'b1;
          cmp_vld_d = 1'b1;
          if (walk_last) begin
            issue_done_d = 1'b1;
          end
        end
        // Compare side: a changed slot is reported and the reported copy catches up.
        if (cmp_vld_q) begin
          if (live_rdata != rep_rdata) begin
            rep_we       = 1'b1;
            rep_waddr    = cmp_slot_q;
            rep_wdata    = live_rdata;
            res_valid_d  = 1'b1;
            res_d.kind   = K_SENT;
            res_d.status = CcStatus | {4'h0, cmp_bus_q};
            res_d.number = cmp_number_q;
            res_d.value  = {live_rdata[4:0], 2'b00};
          end
          if (cmp_last_q) begin
            state_d = ST_DONE;
          end
        end
      end

      ST_DONE: begin
        res_valid_d = 1'b1;
        res_d.kind  = K_DONE;
        res_d.last  = 1'b1;
        state_d     = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_q        <= '0;
      issue_done_q <= 1'b0;
      cmp_vld_q    <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      issue_done_q <= issue_done_d;
      cmp_vld_q    <= cmp_vld_d;
      res_valid_q  <= res_valid_d;
    end
  end

  // Compare-stage payload tracks the slot whose read data arrives next cycle.
  always_ff @(posedge clk_i) begin
    if (walk_step) begin
      cmp_slot_q   <= walk_slot;
      cmp_bus_q    <= walk_bus;
      cmp_number_q <= walk_number;
      cmp_last_q   <= walk_last;
    end
    res_q <= res_d;
  end

  assign result_valid_o = res_valid_q;
  assign kind_o         = res_q.kind;
  assign bus_number_o   = res_q.bus;
  assign target_kind_o  = res_q.target;
  assign input_number_o = res_q.in_num;
  assign apply_level_o  = res_q.level;
  assign out_status_o   = res_q.status;
  assign out_number_o   = res_q.number;
  assign out_value_o    = res_q.value;
  assign last_o         = res_q.last;

`ifndef SYNTHESIS
  // An apply command is always followed at once by its echoed control change.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (kind_o == K_APPLY) |=> result_valid_o && (kind_o == K_SENT))
    else $error("apply not followed by echoed control change");

  // The scan done marker closes the scan.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (kind_o == K_DONE) |-> last_o)
    else $error("scan done marker without last");

  // A MIDI word or a scan keeps the block busy in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && ((action_i == A_MIDI) || (action_i == A_SCAN)) |=> busy_o)
    else $error("block not busy after accepting a word");
`endif

endmodule
